// ===== hw/rtl/caps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// caps_pkg
// Shared types and constants for the congestion aware path selector.
// ----------------------------------------------------------------------------
package caps_pkg;

   localparam int MAX_PATHS   = 64;
   localparam int PATH_AW     = $clog2(MAX_PATHS);
   localparam int PATH_CNT_W  = $clog2(MAX_PATHS + 1);
   localparam int GROUP_COUNT = 64;
   localparam int GROUP_AW    = $clog2(GROUP_COUNT);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ECN_LOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ECN_HIGH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATHS_USED = 2'd2;

   localparam logic [1:0] ACT_SET_GROUP = 2'd0;
   localparam logic [1:0] ACT_SET_ECN   = 2'd1;
   localparam logic [1:0] ACT_CHOOSE    = 2'd2;
   localparam logic [1:0] ACT_UNUSED    = 2'd3;

   localparam logic [1:0] KIND_GOOD = 2'd0;
   localparam logic [1:0] KIND_GRAY = 2'd1;
   localparam logic [1:0] KIND_KEEP = 2'd2;

   localparam logic [7:0]  GROUP_NONE = 8'hFF;
   localparam logic [15:0] ECN_MAX    = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  action;
      logic [5:0]  path_idx;
      logic [7:0]  group_id;
      logic [15:0] ecn_value;
   } req_type;

   typedef struct packed {
      logic [5:0] chosen_path;
      logic [1:0] choice_kind;
   } rsp_type;

   typedef struct packed {
      logic [15:0]           ecn_low;
      logic [15:0]           ecn_high;
      logic [PATH_CNT_W-1:0] path_count;
   } cfg_type;

   typedef enum logic [1:0] {
      CMD_SET_GROUP = 2'd0,
      CMD_SET_ECN   = 2'd1,
      CMD_CHOOSE    = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [5:0]   path_idx;
      logic [7:0]   group_id;
      logic [15:0]  ecn_value;
   } cmd_type;

endpackage
`default_nettype wire

// ===== hw/rtl/congestion_aware_path_selector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// congestion_aware_path_selector
// Chooses a path for a flow from a path-to-group table and per-group ECN.
// ----------------------------------------------------------------------------
// latency: a path choice answers after the command queue, the ring scan and the
//   drain; an out of range current path is answered in idle; table writes give none
// throughput: a choice holds the back end through scan and drain, one path entry
//   read per cycle in scan, table writes on pop; a two entry command queue in front
// reset: synchronous; thresholds 0, one path in use, table entries read as
//   invalid group and zero ECN until written; results cannot be stalled
module congestion_aware_path_selector
   import caps_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire [CSR_IDX_W-1:0]   csr_index,
   input  wire [CSR_DATA_W-1:0]  csr_data
);

   logic [15:0]           ecn_low_ff;
   logic [15:0]           ecn_high_ff;
   logic [6:0]            paths_ff;
   cfg_type               cfg;
   logic                  head_valid;
   cmd_type               head;
   logic                  pop;
   logic                  csr_transfer;

   assign csr_ready    = 1'b1;
   assign csr_transfer = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ecn_low_ff  <= '0;
         ecn_high_ff <= '0;
         paths_ff    <= 7'd1;
      end else if (csr_transfer) begin
         case (csr_index)
            CSR_ECN_LOW:    ecn_low_ff  <= csr_data;
            CSR_ECN_HIGH:   ecn_high_ff <= csr_data;
            CSR_PATHS_USED: paths_ff    <= csr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   // saturate the path count at the table size
   always_comb begin
      cfg.ecn_low    = ecn_low_ff;
      cfg.ecn_high   = ecn_high_ff;
      cfg.path_count = ({1'b0, paths_ff} > 8'(MAX_PATHS)) ? PATH_CNT_W'(MAX_PATHS)
                                                         : PATH_CNT_W'(paths_ff);
   end

   caps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   caps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/caps_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// caps_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module caps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire [$clog2(DEPTH)-1:0]  waddr,
   input  wire [WIDTH-1:0]          wdata,
   input  wire [$clog2(DEPTH)-1:0]  raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

// ===== hw/rtl/caps_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// caps_front
// Accepts requests, decodes the action and queues commands for the back end.
// ----------------------------------------------------------------------------
module caps_front
   import caps_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  wire      start,
   output logic     busy,
   input  req_type  req_data,
   input  wire      pop,
   output logic     head_valid,
   output cmd_type  head
);

   cmd_type           q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              keep;
   logic              push;
   cmd_type           cmd;

   // decode, dropping unused actions and out of range targets
   always_comb begin
      keep           = 1'b0;
      cmd.kind       = CMD_CHOOSE;
      cmd.path_idx   = req_data.path_idx;
      cmd.group_id   = req_data.group_id;
      cmd.ecn_value  = req_data.ecn_value;
      case (req_data.action)
         ACT_SET_GROUP: begin
            cmd.kind = CMD_SET_GROUP;
            keep     = ({1'b0, req_data.path_idx} < PATH_CNT_W'(MAX_PATHS));
         end
         ACT_SET_ECN: begin
            cmd.kind = CMD_SET_ECN;
            keep     = ({1'b0, req_data.group_id} < 9'(GROUP_COUNT));
         end
         ACT_CHOOSE: begin
            cmd.kind = CMD_CHOOSE;
            keep     = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign busy       = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign push       = start && !busy && keep;
   assign head_valid = (cnt_ff != '0);
   assign head       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop && head_valid) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !(pop && head_valid)) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && pop && head_valid) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/caps_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// caps_back
// Executes table writes and runs the ring scan over the path and ECN tables.
// ----------------------------------------------------------------------------
module caps_back
   import caps_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  cfg_type  cfg,
   input  wire      head_valid,
   input  cmd_type  head,
   output logic     pop,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [MAX_PATHS-1:0]   pv_ff, pv_in;
   logic [GROUP_COUNT-1:0] ev_ff, ev_in;

   logic                   path_we, ecn_we;
   logic [7:0]             path_rdata;
   logic [15:0]            ecn_rdata;
   logic [GROUP_AW-1:0]    ecn_raddr;

   logic [PATH_AW-1:0]     p_ff, p_in;
   logic [PATH_AW-1:0]     rem_ff, rem_in;
   logic                   first_ff, first_in;
   logic [PATH_AW-1:0]     cur_ff, cur_in;
   logic [PATH_CNT_W-1:0]  p_next;

   logic                   b_vld_ff, b_vld_in;
   logic                   b_first_ff;
   logic                   b_pv_ff;
   logic [PATH_AW-1:0]     b_path_ff;
   logic [7:0]             b_group;

   logic                   c_vld_ff;
   logic                   c_first_ff;
   logic                   c_gvalid_ff;
   logic                   c_ev_ff;
   logic [PATH_AW-1:0]     c_path_ff;
   logic [15:0]            c_ecn;
   logic                   c_ok;

   logic [15:0]            cur_ecn_ff;
   logic                   good_ff, good_in;
   logic                   gray_ff, gray_in;
   logic [PATH_AW-1:0]     good_path_ff, gray_path_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic                   in_range;

   caps_ram #(.WIDTH(8), .DEPTH(MAX_PATHS)) u_path_ram (
      .clock (clock),
      .we    (path_we),
      .waddr (head.path_idx[PATH_AW-1:0]),
      .wdata (head.group_id),
      .raddr (p_ff),
      .rdata (path_rdata)
   );

   caps_ram #(.WIDTH(16), .DEPTH(GROUP_COUNT)) u_ecn_ram (
      .clock (clock),
      .we    (ecn_we),
      .waddr (head.group_id[GROUP_AW-1:0]),
      .wdata (head.ecn_value),
      .raddr (ecn_raddr),
      .rdata (ecn_rdata)
   );

   assign in_range = ({1'b0, head.path_idx} < cfg.path_count);
   assign p_next   = PATH_CNT_W'(p_ff) + 1'b1;

   // stage b: group lookup, stage c: ecn lookup and classification
   assign b_group   = b_pv_ff ? path_rdata : GROUP_NONE;
   assign ecn_raddr = b_group[GROUP_AW-1:0];
   assign c_ecn     = c_ev_ff ? ecn_rdata : '0;
   assign c_ok      = c_gvalid_ff && (c_ecn <= cur_ecn_ff);

   always_comb begin
      state_in     = state_ff;
      pop          = 1'b0;
      path_we      = 1'b0;
      ecn_we       = 1'b0;
      pv_in        = pv_ff;
      ev_in        = ev_ff;
      p_in         = p_ff;
      rem_in       = rem_ff;
      first_in     = first_ff;
      cur_in       = cur_ff;
      b_vld_in     = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               case (head.kind)
                  CMD_SET_GROUP: begin
                     path_we = 1'b1;
                     pv_in[head.path_idx[PATH_AW-1:0]] = 1'b1;
                  end
                  CMD_SET_ECN: begin
                     ecn_we = 1'b1;
                     ev_in[head.group_id[GROUP_AW-1:0]] = 1'b1;
                  end
                  CMD_CHOOSE: begin
                     cur_in = head.path_idx[PATH_AW-1:0];
                     if (in_range) begin
                        p_in     = head.path_idx[PATH_AW-1:0];
                        rem_in   = PATH_AW'(cfg.path_count - 1'b1);
                        first_in = 1'b1;
                        state_in = S_SCAN;
                     end else begin
                        rsp_valid_in            = 1'b1;
                        rsp_data_in.chosen_path = head.path_idx;
                        rsp_data_in.choice_kind = KIND_KEEP;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            b_vld_in = 1'b1;
            first_in = 1'b0;
            p_in     = (p_next >= cfg.path_count) ? '0 : p_next[PATH_AW-1:0];
            if (rem_ff == '0) begin
               state_in = S_DRAIN;
            end else begin
               rem_in = rem_ff - 1'b1;
            end
         end
         S_DRAIN: begin
            if (!b_vld_ff && !c_vld_ff) begin
               rsp_valid_in = 1'b1;
               if (good_ff) begin
                  rsp_data_in.chosen_path = good_path_ff;
                  rsp_data_in.choice_kind = KIND_GOOD;
               end else if (gray_ff) begin
                  rsp_data_in.chosen_path = gray_path_ff;
                  rsp_data_in.choice_kind = KIND_GRAY;
               end else begin
                  rsp_data_in.chosen_path = cur_ff;
                  rsp_data_in.choice_kind = KIND_KEEP;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      good_in = good_ff;
      gray_in = gray_ff;
      if (state_ff == S_IDLE) begin
         good_in = 1'b0;
         gray_in = 1'b0;
      end else if (c_vld_ff && !c_first_ff && c_ok) begin
         if (c_ecn < cfg.ecn_low) begin
            good_in = 1'b1;
         end else if (c_ecn < cfg.ecn_high) begin
            gray_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pv_ff        <= '0;
         ev_ff        <= '0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         good_ff      <= 1'b0;
         gray_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
         rem_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         pv_ff        <= pv_in;
         ev_ff        <= ev_in;
         b_vld_ff     <= b_vld_in;
         c_vld_ff     <= b_vld_ff;
         good_ff      <= good_in;
         gray_ff      <= gray_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
      b_first_ff  <= first_ff;
      b_pv_ff     <= pv_ff[p_ff];
      b_path_ff   <= p_ff;
      c_first_ff  <= b_first_ff;
      c_gvalid_ff <= ({1'b0, b_group} < 9'(GROUP_COUNT));
      c_ev_ff     <= ev_ff[ecn_raddr];
      c_path_ff   <= b_path_ff;
      if (c_vld_ff && c_first_ff) begin
         cur_ecn_ff <= c_gvalid_ff ? c_ecn : ECN_MAX;
      end
      if (!good_ff && good_in) begin
         good_path_ff <= c_path_ff;
      end
      if (!gray_ff && gray_in) begin
         gray_path_ff <= c_path_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_issue_in_scan: assert property (@(posedge clock) disable iff (reset)
      b_vld_ff |-> $past(state_ff == S_SCAN))
      else $error("path lookup issued outside scan");

   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      c_vld_ff |-> $past(b_vld_ff))
      else $error("ecn stage without group stage");

   a_found_other: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.choice_kind != KIND_KEEP)
         |-> (rsp_data_ff.chosen_path != cur_ff))
      else $error("found path equals current path");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN && state_in == S_IDLE) |-> !c_vld_ff && !b_vld_ff)
      else $error("response issued with scan in flight");

endmodule
`default_nettype wire
